// ----- rtl/core/sit_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the segment intersection test.
package sit_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int WIDE_W     = 10 * COORD_W + 40;
	localparam int TOL_W      = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic MODE_PLANAR = 1'b0;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic [TOL_W-1:0]          tol_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 2'd0,
		REG_TOL  = 2'd1,
		REG_EPS  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
		coord_t d_x;
		coord_t d_y;
		coord_t d_z;
	} seg_in_t;

	typedef struct packed {
		logic intersects;
		logic degenerate;
	} seg_out_t;

	typedef struct packed {
		logic  mode;
		tol_t  tol;
		tol_t  eps;
		diff_t ab_x;
		diff_t ab_y;
		diff_t ab_z;
		diff_t cd_x;
		diff_t cd_y;
		diff_t cd_z;
		diff_t ac_x;
		diff_t ac_y;
		diff_t ac_z;
	} job_t;

	typedef struct packed {
		logic active;
		logic mul_busy;
	} back_stat_t;

endpackage

// ----- rtl/core/sit_front.sv -----
`timescale 1ns / 1ps
// Front end: forms the edge vectors of a segment pair and tags the test mode.
module sit_front (
	input  sit_pkg::seg_in_t operands,
	input  logic             mode,
	input  sit_pkg::tol_t    tol,
	input  sit_pkg::tol_t    eps,
	output sit_pkg::job_t    job
);

	function automatic sit_pkg::diff_t sx(input sit_pkg::coord_t c);
		return {c[sit_pkg::COORD_W-1], c};
	endfunction

	always_comb begin
		job.mode = mode;
		job.tol  = tol;
		job.eps  = eps;
		job.ab_x = sx(operands.b_x) - sx(operands.a_x);
		job.ab_y = sx(operands.b_y) - sx(operands.a_y);
		job.ab_z = sx(operands.b_z) - sx(operands.a_z);
		job.cd_x = sx(operands.d_x) - sx(operands.c_x);
		job.cd_y = sx(operands.d_y) - sx(operands.c_y);
		job.cd_z = sx(operands.d_z) - sx(operands.c_z);
		job.ac_x = sx(operands.c_x) - sx(operands.a_x);
		job.ac_y = sx(operands.c_y) - sx(operands.a_y);
		job.ac_z = sx(operands.c_z) - sx(operands.a_z);
	end

endmodule

// ----- rtl/core/sit_queue.sv -----
`timescale 1ns / 1ps
// Job queue between the front end and the back end.
module sit_queue #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  sit_pkg::job_t              din,
	input  logic                       pop,
	output sit_pkg::job_t              dout,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	sit_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign count = count_q;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/sit_mul.sv -----
`timescale 1ns / 1ps
// Shared radix-2 shift-add multiplier for wide signed operands.
module sit_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  sit_pkg::wide_t a,
	input  sit_pkg::wide_t b,
	output logic           done,
	output sit_pkg::wide_t p
);

	localparam int W = sit_pkg::WIDE_W;

	logic [W-1:0]   ma_q;
	logic [W-1:0]   mb_q;
	logic [W-1:0]   acc_q;
	logic           neg_q;
	logic           run_q;
	logic           done_q;
	sit_pkg::wide_t p_q;

	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;

	assign a_mag = a[W-1] ? W'(-a) : W'(a);
	assign b_mag = b[W-1] ? W'(-b) : W'(b);
	assign done  = done_q;
	assign p     = p_q;

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a_mag;
			mb_q  <= b_mag;
			acc_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (run_q) begin
			if (mb_q == '0) begin
				p_q <= neg_q ? sit_pkg::wide_t'(-acc_q) : sit_pkg::wide_t'(acc_q);
			end else begin
				if (mb_q[0]) begin
					acc_q <= acc_q + ma_q;
				end
				ma_q <= {ma_q[W-2:0], 1'b0};
				mb_q <= {1'b0, mb_q[W-1:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && (mb_q == '0)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/sit_back.sv -----
`timescale 1ns / 1ps
// Back end: sequencer that runs the planar or spatial test on the shared multiplier.
module sit_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  sit_pkg::job_t       q_head,
	output logic                q_pop,
	output logic                done,
	output sit_pkg::seg_out_t   result,
	output sit_pkg::back_stat_t stat
);

	localparam int PC_W = 7;
	localparam logic [PC_W-1:0] L_PLANAR = 7'd40;
	localparam logic [PC_W-1:0] L_P2     = 7'd60;
	localparam sit_pkg::wide_t  ZERO     = '0;

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_MULW} state_t;

	typedef enum logic [3:0] {
		K_MSET, K_MADD, K_MSUB, K_BRMODE, K_DEGS, K_DEGP, K_NORM,
		K_SUBX, K_PCHK1, K_PCHK2, K_PCMP1, K_FINP, K_FINS
	} kind_t;

	typedef enum logic [4:0] {
		O_ABX, O_ABY, O_ABZ, O_CDX, O_CDY, O_CDZ, O_ACX, O_ACY, O_ACZ,
		O_TOL, O_EPS, O_NAB, O_NCD, O_DOT, O_DET, O_DACAB, O_DACCD,
		O_NR, O_NS, O_G, O_GAP, O_LIM, O_TOL2
	} opnd_t;

	typedef struct packed {
		kind_t kind;
		opnd_t a;
		opnd_t b;
		opnd_t dst;
	} uop_t;

	state_t            state_q;
	logic [PC_W-1:0]   pc_q;
	logic              done_q;
	sit_pkg::seg_out_t res_q;

	sit_pkg::job_t  job_q;
	sit_pkg::wide_t nab_q, ncd_q, dot_q, det_q, dacab_q, daccd_q;
	sit_pkg::wide_t nr_q, ns_q, g_q, gap_q, lim_q, tol2_q;

	uop_t           uop;
	sit_pkg::wide_t ra, rb, rd;
	logic           mul_start, mul_done;
	sit_pkg::wide_t mul_p;
	logic           wr_en, norm_en;
	opnd_t          wr_dst;
	sit_pkg::wide_t wr_val;
	sit_pkg::wide_t det_abs, thr_s;
	logic           fin_en, jump_en;
	logic [PC_W-1:0] jump_pc;
	sit_pkg::seg_out_t fin_res;

	function automatic uop_t mk(input kind_t k, input opnd_t a, input opnd_t b,
	                            input opnd_t d);
		uop_t u;
		u.kind = k;
		u.a    = a;
		u.b    = b;
		u.dst  = d;
		return u;
	endfunction

	function automatic uop_t prog(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			7'd0:  u = mk(K_MSET,   O_TOL,   O_TOL,   O_TOL2);
			7'd1:  u = mk(K_BRMODE, O_TOL,   O_TOL,   O_TOL2);
			// spatial: squared lengths, cross dot product, determinant, degeneracy check and numerators
			7'd2:  u = mk(K_MSET,   O_ABX,   O_ABX,   O_NAB);
			7'd3:  u = mk(K_MADD,   O_ABY,   O_ABY,   O_NAB);
			7'd4:  u = mk(K_MADD,   O_ABZ,   O_ABZ,   O_NAB);
			7'd5:  u = mk(K_MSET,   O_CDX,   O_CDX,   O_NCD);
			7'd6:  u = mk(K_MADD,   O_CDY,   O_CDY,   O_NCD);
			7'd7:  u = mk(K_MADD,   O_CDZ,   O_CDZ,   O_NCD);
			7'd8:  u = mk(K_MSET,   O_ABX,   O_CDX,   O_DOT);
			7'd9:  u = mk(K_MADD,   O_ABY,   O_CDY,   O_DOT);
			7'd10: u = mk(K_MADD,   O_ABZ,   O_CDZ,   O_DOT);
			7'd11: u = mk(K_MSET,   O_DOT,   O_DOT,   O_DET);
			7'd12: u = mk(K_MSUB,   O_NAB,   O_NCD,   O_DET);
			7'd13: u = mk(K_DEGS,   O_DET,   O_DET,   O_DET);
			7'd14: u = mk(K_MSET,   O_ABX,   O_ACX,   O_DACAB);
			7'd15: u = mk(K_MADD,   O_ABY,   O_ACY,   O_DACAB);
			7'd16: u = mk(K_MADD,   O_ABZ,   O_ACZ,   O_DACAB);
			7'd17: u = mk(K_MSET,   O_CDX,   O_ACX,   O_DACCD);
			7'd18: u = mk(K_MADD,   O_CDY,   O_ACY,   O_DACCD);
			7'd19: u = mk(K_MADD,   O_CDZ,   O_ACZ,   O_DACCD);
			7'd20: u = mk(K_MSET,   O_DOT,   O_DACCD, O_NR);
			7'd21: u = mk(K_MSUB,   O_DACAB, O_NCD,   O_NR);
			7'd22: u = mk(K_MSET,   O_DACCD, O_NAB,   O_NS);
			7'd23: u = mk(K_MSUB,   O_DACAB, O_DOT,   O_NS);
			7'd24: u = mk(K_NORM,   O_DET,   O_DET,   O_DET);
			// gap vector times det, one axis at a time
			7'd25: u = mk(K_MSET,   O_DET,   O_ACX,   O_G);
			7'd26: u = mk(K_MADD,   O_NS,    O_CDX,   O_G);
			7'd27: u = mk(K_MSUB,   O_NR,    O_ABX,   O_G);
			7'd28: u = mk(K_MSET,   O_G,     O_G,     O_GAP);
			7'd29: u = mk(K_MSET,   O_DET,   O_ACY,   O_G);
			7'd30: u = mk(K_MADD,   O_NS,    O_CDY,   O_G);
			7'd31: u = mk(K_MSUB,   O_NR,    O_ABY,   O_G);
			7'd32: u = mk(K_MADD,   O_G,     O_G,     O_GAP);
			7'd33: u = mk(K_MSET,   O_DET,   O_ACZ,   O_G);
			7'd34: u = mk(K_MADD,   O_NS,    O_CDZ,   O_G);
			7'd35: u = mk(K_MSUB,   O_NR,    O_ABZ,   O_G);
			7'd36: u = mk(K_MADD,   O_G,     O_G,     O_GAP);
			7'd37: u = mk(K_MSET,   O_DET,   O_DET,   O_LIM);
			7'd38: u = mk(K_MSET,   O_LIM,   O_TOL2,  O_LIM);
			7'd39: u = mk(K_FINS,   O_DET,   O_DET,   O_DET);
			// planar: Cramer numerators and determinant, degeneracy check, then both bound checks
			7'd40: u = mk(K_MSET,   O_CDX,   O_ABY,   O_DET);
			7'd41: u = mk(K_MSUB,   O_ABX,   O_CDY,   O_DET);
			7'd42: u = mk(K_MSET,   O_CDX,   O_ACY,   O_NR);
			7'd43: u = mk(K_MSUB,   O_ACX,   O_CDY,   O_NR);
			7'd44: u = mk(K_MSET,   O_ABX,   O_ACY,   O_NS);
			7'd45: u = mk(K_MSUB,   O_ACX,   O_ABY,   O_NS);
			7'd46: u = mk(K_MSET,   O_EPS,   O_EPS,   O_LIM);
			7'd47: u = mk(K_DEGP,   O_DET,   O_DET,   O_DET);
			7'd48: u = mk(K_NORM,   O_DET,   O_DET,   O_DET);
			7'd49: u = mk(K_MSET,   O_ABX,   O_ABX,   O_NAB);
			7'd50: u = mk(K_MADD,   O_ABY,   O_ABY,   O_NAB);
			7'd51: u = mk(K_MSET,   O_CDX,   O_CDX,   O_NCD);
			7'd52: u = mk(K_MADD,   O_CDY,   O_CDY,   O_NCD);
			7'd53: u = mk(K_MSET,   O_DET,   O_DET,   O_LIM);
			7'd54: u = mk(K_MSET,   O_LIM,   O_TOL2,  O_LIM);
			7'd55: u = mk(K_SUBX,   O_NR,    O_DET,   O_G);
			7'd56: u = mk(K_PCHK1,  O_NR,    O_DET,   O_G);
			7'd57: u = mk(K_MSET,   O_G,     O_G,     O_GAP);
			7'd58: u = mk(K_MSET,   O_GAP,   O_NAB,   O_GAP);
			7'd59: u = mk(K_PCMP1,  O_GAP,   O_LIM,   O_GAP);
			7'd60: u = mk(K_SUBX,   O_NS,    O_DET,   O_G);
			7'd61: u = mk(K_PCHK2,  O_NS,    O_DET,   O_G);
			7'd62: u = mk(K_MSET,   O_G,     O_G,     O_GAP);
			7'd63: u = mk(K_MSET,   O_GAP,   O_NCD,   O_GAP);
			7'd64: u = mk(K_FINP,   O_GAP,   O_LIM,   O_GAP);
			default: u = mk(K_FINP, O_GAP,   O_LIM,   O_GAP);
		endcase
		return u;
	endfunction

	function automatic sit_pkg::wide_t sxw(input sit_pkg::diff_t d);
		return {{(sit_pkg::WIDE_W - sit_pkg::DIFF_W){d[sit_pkg::DIFF_W-1]}}, d};
	endfunction

	function automatic sit_pkg::wide_t zxw(input sit_pkg::tol_t t);
		return {{(sit_pkg::WIDE_W - sit_pkg::TOL_W){1'b0}}, t};
	endfunction

	function automatic sit_pkg::wide_t sel(input opnd_t o);
		sit_pkg::wide_t v;
		case (o)
			O_ABX:   v = sxw(job_q.ab_x);
			O_ABY:   v = sxw(job_q.ab_y);
			O_ABZ:   v = sxw(job_q.ab_z);
			O_CDX:   v = sxw(job_q.cd_x);
			O_CDY:   v = sxw(job_q.cd_y);
			O_CDZ:   v = sxw(job_q.cd_z);
			O_ACX:   v = sxw(job_q.ac_x);
			O_ACY:   v = sxw(job_q.ac_y);
			O_ACZ:   v = sxw(job_q.ac_z);
			O_TOL:   v = zxw(job_q.tol);
			O_EPS:   v = zxw(job_q.eps);
			O_NAB:   v = nab_q;
			O_NCD:   v = ncd_q;
			O_DOT:   v = dot_q;
			O_DET:   v = det_q;
			O_DACAB: v = dacab_q;
			O_DACCD: v = daccd_q;
			O_NR:    v = nr_q;
			O_NS:    v = ns_q;
			O_G:     v = g_q;
			O_GAP:   v = gap_q;
			O_LIM:   v = lim_q;
			O_TOL2:  v = tol2_q;
			default: v = ZERO;
		endcase
		return v;
	endfunction

	assign uop = prog(pc_q);

	always_comb begin
		ra = sel(uop.a);
		rb = sel(uop.b);
		rd = sel(uop.dst);
	end

	assign mul_start = (state_q == ST_EXEC) &&
	                   ((uop.kind == K_MSET) || (uop.kind == K_MADD) || (uop.kind == K_MSUB));

	sit_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (ra),
		.b      (rb),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign q_pop   = (state_q == ST_IDLE) && !q_empty;
	assign det_abs = det_q[sit_pkg::WIDE_W-1] ? -det_q : det_q;
	assign thr_s   = zxw(job_q.eps) << (3 * sit_pkg::FRAC_BITS);

	// Register file write: multiplier result or a subtract step; sign normalisation of det, nr and ns.
	always_comb begin
		wr_en   = 1'b0;
		wr_dst  = uop.dst;
		wr_val  = mul_p;
		norm_en = 1'b0;
		if ((state_q == ST_MULW) && mul_done) begin
			wr_en = 1'b1;
			case (uop.kind)
				K_MADD:  wr_val = rd + mul_p;
				K_MSUB:  wr_val = rd - mul_p;
				default: wr_val = mul_p;
			endcase
		end else if (state_q == ST_EXEC) begin
			if (uop.kind == K_SUBX) begin
				wr_en  = 1'b1;
				wr_val = ra - rb;
			end
			norm_en = (uop.kind == K_NORM) && det_q[sit_pkg::WIDE_W-1];
		end
	end

	// Control decisions of the current step.
	always_comb begin
		fin_en  = 1'b0;
		fin_res = '0;
		jump_en = 1'b0;
		jump_pc = L_PLANAR;
		case (uop.kind)
			K_BRMODE: begin
				jump_en = (job_q.mode == sit_pkg::MODE_PLANAR);
			end
			K_DEGS: begin
				fin_en             = (det_q == ZERO) || (det_abs < thr_s);
				fin_res.degenerate = 1'b1;
			end
			K_DEGP: begin
				fin_en             = (det_q == ZERO) || (det_abs < lim_q);
				fin_res.degenerate = 1'b1;
			end
			K_PCHK1: begin
				if (ra <= ZERO) begin
					fin_en = 1'b1;
				end else if (g_q < ZERO) begin
					jump_en = 1'b1;
					jump_pc = L_P2;
				end
			end
			K_PCHK2: begin
				if (ra <= ZERO) begin
					fin_en = 1'b1;
				end else if (g_q < ZERO) begin
					fin_en             = 1'b1;
					fin_res.intersects = 1'b1;
				end
			end
			K_PCMP1: begin
				fin_en = !(gap_q < lim_q);
			end
			K_FINP: begin
				fin_en             = 1'b1;
				fin_res.intersects = gap_q < lim_q;
			end
			K_FINS: begin
				fin_en             = 1'b1;
				fin_res.intersects = (nr_q > ZERO) && (nr_q < det_q) &&
				                     (ns_q > ZERO) && (ns_q < det_q) && (gap_q < lim_q);
			end
			default: begin
				fin_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (norm_en) begin
			det_q <= -det_q;
			nr_q  <= -nr_q;
			ns_q  <= -ns_q;
		end
		if (wr_en) begin
			case (wr_dst)
				O_NAB:   nab_q   <= wr_val;
				O_NCD:   ncd_q   <= wr_val;
				O_DOT:   dot_q   <= wr_val;
				O_DET:   det_q   <= wr_val;
				O_DACAB: dacab_q <= wr_val;
				O_DACCD: daccd_q <= wr_val;
				O_NR:    nr_q    <= wr_val;
				O_NS:    ns_q    <= wr_val;
				O_G:     g_q     <= wr_val;
				O_GAP:   gap_q   <= wr_val;
				O_LIM:   lim_q   <= wr_val;
				O_TOL2:  tol2_q  <= wr_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_EXEC;
						pc_q    <= '0;
					end
				end
				ST_EXEC: begin
					if (mul_start) begin
						state_q <= ST_MULW;
					end else if (fin_en) begin
						done_q  <= 1'b1;
						res_q   <= fin_res;
						state_q <= ST_IDLE;
					end else if (jump_en) begin
						pc_q <= jump_pc;
					end else begin
						pc_q <= pc_q + PC_W'(1);
					end
				end
				ST_MULW: begin
					if (mul_done) begin
						pc_q    <= pc_q + PC_W'(1);
						state_q <= ST_EXEC;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign result        = res_q;
	assign stat.active   = (state_q != ST_IDLE);
	assign stat.mul_busy = (state_q == ST_MULW);

endmodule

// ----- rtl/core/segment_intersection_test.sv -----
`timescale 1ns / 1ps
// Top level of the segment intersection test: config registers, front end, queue, back end.
//
// Usage:
//   Input: drive operands (segments AB and CD, Q16.16 signed) with start; the pair
//   is transferred at a rising edge with start high and busy low. Pairs may follow
//   each other in consecutive cycles until the job queue is full; busy then holds
//   off further transfers.
//   Output: each pair yields one result (intersects, degenerate) on result, valid
//   for exactly one cycle while done is high; the receiver cannot stall, so the
//   result must be taken in that cycle. Results leave in input order.
//   Config: cfg_valid/cfg_ready (ready is always high) with cfg_index 0 = mode
//   (0 planar, 1 spatial), 1 = hit tolerance, 2 = degeneracy threshold; other
//   indexes are ignored. Write only while no pair is in flight.
//   Timing: the back end runs a short step program on one shared radix-2
//   multiplier. Each product takes longer the more significant bits the second
//   operand's magnitude has, so the time per pair follows the data. The back end
//   takes the next pair from the queue only once it has finished the last one;
//   that multiplier sets throughput.
//   Reset: arst_n clears the queue, the sequencer and the registers to mode 1,
//   tolerance 0, threshold 1. No clearing pass is needed.
module segment_intersection_test #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  sit_pkg::seg_in_t                   operands,
	output logic                               done,
	output sit_pkg::seg_out_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sit_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sit_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                             mode_q;
	sit_pkg::tol_t                    tol_q;
	sit_pkg::tol_t                    eps_q;

	sit_pkg::job_t                    front_job;
	sit_pkg::job_t                    q_head;
	logic                             q_push, q_pop, q_empty, q_full;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	sit_pkg::back_stat_t              back_stat;

	assign cfg_ready = 1'b1;

	// Hold the config registers; mask writes to the register width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			tol_q  <= '0;
			eps_q  <= sit_pkg::tol_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sit_pkg::REG_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index == sit_pkg::REG_TOL) begin
				tol_q <= cfg_data[sit_pkg::TOL_W-1:0];
			end else if (cfg_index == sit_pkg::REG_EPS) begin
				eps_q <= cfg_data[sit_pkg::TOL_W-1:0];
			end
		end
	end

	// Accept a pair whenever the queue has room.
	assign busy   = q_full;
	assign q_push = start && !busy;

	sit_front u_front (
		.operands (operands),
		.mode     (mode_q),
		.tol      (tol_q),
		.eps      (eps_q),
		.job      (front_job)
	);

	sit_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (front_job),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty),
		.full   (q_full),
		.count  (q_count)
	);

	sit_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result),
		.stat    (back_stat)
	);

`ifndef NO_ASSERTIONS
	a_no_hit_when_degen: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.intersects && result.degenerate))
		else $error("degenerate result reported as a hit");

	a_done_from_active: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(back_stat.active))
		else $error("result strobe without an active back end");

	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes in consecutive cycles");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QUEUE_DEPTH)
		else $error("job queue overfilled");
`endif

endmodule

// ----- tb/segment_intersection_checker.sv -----
`timescale 1ns / 1ps
// Checker: watches the pair, result and register channels, predicts each result and compares.
module segment_intersection_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  sit_pkg::seg_in_t               operands,
	input  logic                           done,
	input  sit_pkg::seg_out_t              result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sit_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import sit_pkg::*;

	localparam int BIG_W = 512;
	typedef logic signed [BIG_W-1:0] big_t;

	logic       mode_q;
	tol_t       tol_q;
	tol_t       eps_q;
	seg_out_t   expected_flags[$];

	// Exact planar bound 0 < num/den < 1 + tol/sqrt(len2), den positive.
	function automatic logic within_bound(big_t num, big_t den, big_t len2, big_t tol2);
		big_t over;
		if (num <= 0)
			return 1'b0;
		over = num - den;
		if (over < 0)
			return 1'b1;
		return (over * over * len2) < (den * den * tol2);
	endfunction

	function automatic big_t dot3(big_t u[3], big_t v[3]);
		return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
	endfunction

	function automatic seg_out_t predict_flags(seg_in_t s, logic mode, tol_t tol, tol_t eps);
		big_t pa[3], pb[3], pc[3], pd[3], ab[3], cd[3], ac[3];
		big_t e, t2, det, adet, thr, nr, ns, lab, lcd;
		big_t nab, ncd, dabcd, dacab, daccd, gap, lim;
		big_t g[3];
		seg_out_t o;
		pa[0] = s.a_x; pa[1] = s.a_y; pa[2] = s.a_z;
		pb[0] = s.b_x; pb[1] = s.b_y; pb[2] = s.b_z;
		pc[0] = s.c_x; pc[1] = s.c_y; pc[2] = s.c_z;
		pd[0] = s.d_x; pd[1] = s.d_y; pd[2] = s.d_z;
		for (int i = 0; i < 3; i++) begin
			ab[i] = pb[i] - pa[i];
			cd[i] = pd[i] - pc[i];
			ac[i] = pc[i] - pa[i];
		end
		e  = eps;
		t2 = tol;
		t2 = t2 * t2;
		o  = '0;
		if (mode == MODE_PLANAR) begin
			det  = cd[0] * ab[1] - ab[0] * cd[1];
			nr   = cd[0] * ac[1] - ac[0] * cd[1];
			ns   = ab[0] * ac[1] - ac[0] * ab[1];
			thr  = e * e;
			adet = (det < 0) ? -det : det;
			if (det == 0 || adet < thr) begin
				o.degenerate = 1'b1;
			end else begin
				if (det < 0) begin
					det = -det; nr = -nr; ns = -ns;
				end
				lab = ab[0] * ab[0] + ab[1] * ab[1];
				lcd = cd[0] * cd[0] + cd[1] * cd[1];
				o.intersects = within_bound(nr, det, lab, t2) && within_bound(ns, det, lcd, t2);
			end
		end else begin
			nab   = dot3(ab, ab);
			ncd   = dot3(cd, cd);
			dabcd = dot3(ab, cd);
			det   = dabcd * dabcd - nab * ncd;
			thr   = e <<< (3 * FRAC_BITS);
			adet  = (det < 0) ? -det : det;
			if (det == 0 || adet < thr) begin
				o.degenerate = 1'b1;
			end else begin
				dacab = dot3(ac, ab);
				daccd = dot3(ac, cd);
				nr    = dabcd * daccd - dacab * ncd;
				ns    = daccd * nab - dacab * dabcd;
				if (det < 0) begin
					det = -det; nr = -nr; ns = -ns;
				end
				// scaled gap vector between the closest points
				for (int i = 0; i < 3; i++)
					g[i] = det * ac[i] + ns * cd[i] - nr * ab[i];
				gap = dot3(g, g);
				lim = det * det * t2;
				o.intersects = nr > 0 && nr < det && ns > 0 && ns < det && gap < lim;
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		seg_out_t want;
		if (!arst_n) begin
			mode_q  <= 1'b1;
			tol_q   <= '0;
			eps_q   <= tol_t'(1);
			errors  <= 0;
			pending <= 0;
			expected_flags.delete();
		end else begin
			if (done) begin
				if (expected_flags.size() == 0) begin
					$display("%0t: result %b with no pair outstanding", $time, result);
					errors <= errors + 1;
				end else begin
					want = expected_flags.pop_front();
					if (result.intersects !== want.intersects) begin
						$display("%0t: intersects expected %b actual %b", $time,
							want.intersects, result.intersects);
						errors <= errors + 1;
					end
					if (result.degenerate !== want.degenerate) begin
						$display("%0t: degenerate expected %b actual %b", $time,
							want.degenerate, result.degenerate);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				expected_flags.push_back(predict_flags(operands, mode_q, tol_q, eps_q));
			pending <= expected_flags.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[0];
					REG_TOL:  tol_q  <= cfg_data[TOL_W-1:0];
					REG_EPS:  eps_q  <= cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the segment intersection testbench: clock, reset, stimulus and verdict.
module testbench;
	import sit_pkg::*;

	localparam int ONE          = 1 << FRAC_BITS;
	localparam int PHASES       = 8;
	localparam int PER_PHASE    = 250;
	localparam int DRAIN_CYCLES = 50;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	seg_in_t                operands = '0;
	logic                   done;
	seg_out_t               result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     errors;
	int                     pending;
	int                     pairs_sent = 0;

	// register settings per phase: mode, tolerance, threshold
	logic phase_mode [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	int   phase_tol  [PHASES] = '{0, 0, 32'h7fffffff, 32'h7fffffff,
		ONE, 1 << 12, 1 << 20, 1 << 18};
	int   phase_eps  [PHASES] = '{1, 1, 0, 0, ONE, 32'h7fffffff, 32'h7fffffff, 1 << 8};

	always #5 clk = ~clk;

	segment_intersection_test dut (.*);

	segment_intersection_checker u_checker (.*);

	// Idle start for random cycles, then hold start and operands until the transfer.
	task automatic send_pair(input seg_in_t p, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		operands <= p;
		start    <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pairs_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop start and wait for every outstanding result.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic seg_in_t make_pair(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz, int dx, int dy, int dz);
		seg_in_t p;
		p = '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
		return p;
	endfunction

	function automatic seg_in_t directed_pair(int k);
		case (k)
			0:  return {12{32'h7fffffff}};
			1:  return {12{32'h80000000}};
			2:  return '0;
			// clean crossing at the origin
			3:  return make_pair(-ONE, -ONE, 0, ONE, ONE, 0, -ONE, ONE, 0, ONE, -ONE, 0);
			// lines meet exactly at the end of AB
			4:  return make_pair(0, 0, 0, 2*ONE, 2*ONE, 0, ONE, 3*ONE, 0, 3*ONE, ONE, 0);
			// parallel and collinear
			5:  return make_pair(0, 0, 0, ONE, ONE, 0, ONE, 0, 0, 2*ONE, ONE, 0);
			6:  return make_pair(0, 0, 0, ONE, ONE, 0, 2*ONE, 2*ONE, 0, 3*ONE, 3*ONE, 0);
			// zero-length first segment
			7:  return make_pair(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 2*ONE, 3*ONE, ONE);
			// near miss: CD ends a hair short of AB
			8:  return make_pair(0, 0, 0, 4*ONE, 0, 0, 2*ONE, 3*ONE, 0, 2*ONE, 16, 0);
			// skew lines, crossing in plan view but one unit apart in z
			9:  return make_pair(-ONE, -ONE, 0, ONE, ONE, 0, -ONE, ONE, ONE, ONE, -ONE, ONE);
			10: return make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
				32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
				32'h7fffffff, 32'h7fffffff, 32'h80000000);
			default: return {6{32'haaaaaaaa, 32'h55555555}};
		endcase
	endfunction

	function automatic int near_coord(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic seg_in_t random_pair();
		seg_in_t p;
		int span, mx, my, mz, vx, vy, vz;
		span = 1 << $urandom_range(4, 24);
		p = make_pair(near_coord(span), near_coord(span), near_coord(span),
			near_coord(span), near_coord(span), near_coord(span),
			near_coord(span), near_coord(span), near_coord(span),
			near_coord(span), near_coord(span), near_coord(span));
		case ($urandom_range(9))
			0: begin
				// raw noise over the full coordinate range
				p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			end
			1, 2, 3, 4: begin
				// CD passes through a point of AB, offset by a small jitter
				mx = p.a_x + (p.b_x - p.a_x) / 2 + near_coord(8);
				my = p.a_y + (p.b_y - p.a_y) / 2 + near_coord(8);
				mz = p.a_z + (p.b_z - p.a_z) / 2 + near_coord($urandom_range(1) ? 0 : 64);
				vx = near_coord(span);
				vy = near_coord(span);
				vz = near_coord(span);
				p.c_x = mx - vx; p.c_y = my - vy; p.c_z = mz - vz;
				p.d_x = mx + vx; p.d_y = my + vy; p.d_z = mz + vz;
			end
			5: begin
				// parallel: CD is AB shifted
				p.d_x = p.c_x + (p.b_x - p.a_x);
				p.d_y = p.c_y + (p.b_y - p.a_y);
				p.d_z = p.c_z + (p.b_z - p.a_z);
			end
			6: begin
				p.b_x = p.a_x; p.b_y = p.a_y; p.b_z = p.a_z;
			end
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		int idle_pct;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// exercise masking of wide data and the ignored spare index
		write_reg(REG_TOL, 32'hffffffff);
		write_reg(REG_SPARE, 32'hffffffff);
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_MODE, {31'd0, phase_mode[ph]});
			write_reg(REG_TOL, phase_tol[ph]);
			write_reg(REG_EPS, phase_eps[ph]);
			idle_pct = (ph < 3) ? 25 : (ph < 6) ? 84 : 0;
			if (ph < 2)
				for (int k = 0; k < 12; k++)
					send_pair(directed_pair(k), idle_pct);
			for (int n = 0; n < PER_PHASE; n++)
				send_pair(random_pair(), idle_pct);
			// hold off the next settings until the block is empty
			drain();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d segment pairs over %0d register settings,", pairs_sent, PHASES);
		$display("planar and spatial, tolerance and threshold at both extremes.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400ms;
		$display("Timeout with %0d results outstanding", pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/sit_pkg.sv
rtl/core/sit_front.sv
rtl/core/sit_queue.sv
rtl/core/sit_mul.sv
rtl/core/sit_back.sv
rtl/core/segment_intersection_test.sv
tb/segment_intersection_checker.sv
tb/testbench.sv
